// ===== design/segmented_prime_sieve_core_macros.svh =====
// Assertion macros shared by the sieve design files
`ifndef SEGMENTED_PRIME_SIEVE_CORE_MACROS_SVH
`define SEGMENTED_PRIME_SIEVE_CORE_MACROS_SVH

// implication checked at every edge outside reset
`define SPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and types for the segmented prime sieve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sps_pkg;
    localparam int SEGMENT_SIZE = 1024;
    localparam int MAX_PRIMES   = 65536;
    localparam int SEG_W        = $clog2(SEGMENT_SIZE);
    localparam int IDX_W        = $clog2(MAX_PRIMES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int TOT_W        = 17;
    localparam int QDEPTH       = 2;

    typedef struct packed {
        logic [31:0] limit;
        logic [15:0] position;
    } t_query;
endpackage

// ===== design/segmented_prime_sieve_core.sv =====
// ----------------------------------------------------------------------------
// segmented_prime_sieve_core
// Caching segmented sieve: answers prime count and indexed prime queries.
// ----------------------------------------------------------------------------
// channel   signals                              handshake
// query     i_limit, i_position                  start && !busy
// result    o_prime_value, o_found,
//           o_prime_total, o_table_full          o_valid, one cycle
//
// A cached query is answered by a binary search over the prime table: each
// probe waits out the table's registered read. Extending the sieve clears each
// segment, strikes the multiples of each sieving prime after a serial remainder,
// and then collects the survivors into the table.
// busy stays high while the two-entry query queue is full.
// Reset is synchronous; results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segmented_prime_sieve_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_limit,
    input  logic [15:0] i_position,
    output logic        o_valid,
    output logic [31:0] o_prime_value,
    output logic        o_found,
    output logic [16:0] o_prime_total,
    output logic        o_table_full
);
    import sps_pkg::*;

    logic   w_qv, w_pop;
    t_query w_q;

    sps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_limit(i_limit), .i_position(i_position), .o_busy(busy),
        .o_q_valid(w_qv), .o_q_data(w_q), .i_q_pop(w_pop)
    );

    sps_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .i_q_data(w_q),
        .o_q_pop(w_pop), .o_valid(o_valid), .o_prime_value(o_prime_value),
        .o_found(o_found), .o_prime_total(o_prime_total),
        .o_table_full(o_table_full)
    );
endmodule

// ===== design/sps_front.sv =====
// ----------------------------------------------------------------------------
// sps_front
// Query intake: registers accepted queries into a short queue for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sps_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_limit,
    input  logic [15:0]   i_position,
    output logic          o_busy,
    output logic          o_q_valid,
    output sps_pkg::t_query o_q_data,
    input  logic          i_q_pop
);
    import sps_pkg::*;

    t_query     r_mem [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_busy    = (r_cnt == 2'(QDEPTH));
    assign w_push    = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{limit: i_limit, position: i_position};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

`include "segmented_prime_sieve_core_macros.svh"
    `SPS_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_q_pop, o_q_valid)
    `SPS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(QDEPTH))
    `SPS_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, w_push && !i_q_pop, r_cnt != 2'd0)
endmodule

// ===== design/sps_engine.sv =====
// ----------------------------------------------------------------------------
// sps_engine
// Sieve engine: extends the prime table segment by segment, then answers
// the query with a binary search and an indexed table read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sps_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  sps_pkg::t_query i_q_data,
    output logic            o_q_pop,
    output logic            o_valid,
    output logic [31:0]     o_prime_value,
    output logic            o_found,
    output logic [16:0]     o_prime_total,
    output logic            o_table_full
);
    import sps_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_CHK   = 20'h00002,
        S_CLR   = 20'h00004,
        S_S0I   = 20'h00008,
        S_S0W   = 20'h00010,
        S_S0C   = 20'h00020,
        S_S0M   = 20'h00040,
        S_PRD   = 20'h00080,
        S_PWT   = 20'h00100,
        S_PLD   = 20'h00200,
        S_PSQ   = 20'h00400,
        S_PDIV  = 20'h00800,
        S_STRK  = 20'h01000,
        S_COLW  = 20'h02000,
        S_COL   = 20'h04000,
        S_BSRD  = 20'h08000,
        S_BSWT  = 20'h10000,
        S_BSCM  = 20'h20000,
        S_ANS   = 20'h40000,
        S_ANSW  = 20'h80000
    } t_state;

    t_state r_st, n_st;

    logic [31:0]      r_store [MAX_PRIMES];
    logic             r_marks [SEGMENT_SIZE];
    logic [CNT_W-1:0] r_cnt;
    logic [32:0]      r_base;
    t_query           r_q;
    logic [31:0]      r_last;

    logic [IDX_W-1:0] r_raddr;
    logic [31:0]      r_rdata;
    logic             r_mrd;
    logic             r_mwe, r_mwd;
    logic [SEG_W-1:0] r_mwa;
    logic             r_swe;
    logic [IDX_W-1:0] r_swa;
    logic [31:0]      r_swd;

    logic [SEG_W:0]   r_i;
    logic [SEG_W:0]   r_m;
    logic [SEG_W-1:0] r_step;
    logic [CNT_W-1:0] r_k;
    logic [31:0]      r_p;
    logic [63:0]      r_sq;
    logic [32:0]      r_rem;
    logic [5:0]       r_dbit;
    logic [CNT_W-1:0] r_lo, r_hi;
    logic [CNT_W-1:0] w_mid;

    logic [32:0]          w_top;
    logic [32:0]          w_val;
    logic [33:0]          w_trial;
    logic [2*SEG_W+1:0]   w_isq;
    logic                 w_m_in;
    logic                 w_col_end;

    assign w_top     = r_base + 33'(SEGMENT_SIZE - 1);
    assign w_val     = r_base + 33'(r_i[SEG_W-1:0]);
    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_trial   = {r_rem, r_base[r_dbit]} - {2'b0, r_p};
    assign w_isq     = r_i * r_i;
    assign w_m_in    = (r_m < (SEG_W+1)'(SEGMENT_SIZE));
    assign w_col_end = (r_i >= (SEG_W+1)'(SEGMENT_SIZE))
                       || (r_mrd && (w_val > 33'hFFFFFFFF || r_cnt >= CNT_W'(MAX_PRIMES)));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_q_valid) n_st = S_CHK;
            S_CHK: begin
                if (r_cnt < CNT_W'(MAX_PRIMES) && r_base <= {1'b0, r_q.limit})
                    n_st = S_CLR;
                else if (r_cnt == '0)
                    n_st = S_ANS;
                else
                    n_st = S_BSRD;
            end
            S_CLR: if (r_i == (SEG_W+1)'(SEGMENT_SIZE - 1))
                       n_st = (r_base == '0) ? S_S0I : S_PRD;
            S_S0I: begin
                if (w_isq >= (2*SEG_W+2)'(SEGMENT_SIZE)) n_st = S_COLW;
                else n_st = S_S0W;
            end
            S_S0W: n_st = S_S0C;
            S_S0C: n_st = r_mrd ? S_S0M : S_S0I;
            S_S0M: if (!w_m_in) n_st = S_S0I;
            S_PRD: n_st = (r_k >= r_cnt) ? S_COLW : S_PWT;
            S_PWT: n_st = S_PLD;
            S_PLD: n_st = S_PSQ;
            S_PSQ: begin
                if (r_p < 32'd2) n_st = S_PRD;
                else if (r_sq > {31'd0, w_top}) n_st = S_COLW;
                else n_st = S_PDIV;
            end
            S_PDIV: if (r_dbit == 6'd0) n_st = S_STRK;
            S_STRK: if (!w_m_in) n_st = S_PRD;
            S_COLW: n_st = S_COL;
            S_COL:  if (w_col_end) n_st = S_CHK;
            S_BSRD: n_st = (r_lo < r_hi) ? S_BSWT : S_ANS;
            S_BSWT: n_st = S_BSCM;
            S_BSCM: n_st = S_BSRD;
            S_ANS:  n_st = S_ANSW;
            S_ANSW: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_swe) r_store[r_swa] <= r_swd;
        r_rdata <= r_store[r_raddr];
        if (r_mwe) r_marks[r_mwa] <= r_mwd;
        r_mrd <= r_marks[r_mwa];
    end

    always_ff @(posedge i_clk) begin
        r_sq <= r_rdata * r_rdata;
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_cnt   <= '0;
            r_base  <= '0;
            o_valid <= 1'b0;
            r_mwe   <= 1'b0;
            r_swe   <= 1'b0;
        end else begin
            r_st    <= n_st;
            o_valid <= (r_st == S_ANSW);
            r_mwe   <= (r_st == S_CLR) || ((r_st == S_S0M || r_st == S_STRK) && w_m_in);
            r_mwd   <= (r_st == S_CLR) && !(r_base == '0 && r_i < (SEG_W+1)'(2));
            r_swe   <= (r_st == S_COL) && !w_col_end && r_mrd;
            unique case (r_st)
                S_IDLE: if (i_q_valid) r_q <= i_q_data;
                S_CHK: begin
                    r_i <= '0;
                    r_lo <= '0;
                    r_hi <= r_cnt;
                end
                S_CLR: begin
                    r_mwa <= r_i[SEG_W-1:0];
                    r_i   <= (r_i == (SEG_W+1)'(SEGMENT_SIZE - 1)) ? (SEG_W+1)'(2) : r_i + 1'b1;
                    r_k   <= '0;
                end
                S_S0I: begin
                    if (w_isq >= (2*SEG_W+2)'(SEGMENT_SIZE)) begin
                        r_i <= '0;
                        r_mwa <= '0;
                    end else begin
                        r_mwa  <= r_i[SEG_W-1:0];
                        r_m    <= (SEG_W+1)'(w_isq);
                        r_step <= r_i[SEG_W-1:0];
                    end
                end
                S_S0C: if (!r_mrd) r_i <= r_i + 1'b1;
                S_S0M: begin
                    if (!w_m_in) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_mwa <= r_m[SEG_W-1:0];
                        r_m   <= r_m + {1'b0, r_step};
                    end
                end
                S_PRD: begin
                    r_raddr <= r_k[IDX_W-1:0];
                    if (r_k >= r_cnt) begin
                        r_i <= '0;
                        r_mwa <= '0;
                    end
                end
                S_PLD: r_p <= r_rdata;
                S_PSQ: begin
                    r_k <= r_k + 1'b1;
                    r_rem <= '0;
                    r_dbit <= 6'd32;
                    if (r_p >= 32'd2 && r_sq > {31'd0, w_top}) begin
                        r_i <= '0;
                        r_mwa <= '0;
                    end
                end
                S_PDIV: begin
                    r_rem  <= w_trial[33] ? {r_rem[31:0], r_base[r_dbit]} : w_trial[32:0];
                    r_dbit <= r_dbit - 6'd1;
                    if (r_dbit == 6'd0) begin
                        if (w_trial[33]) begin
                            if ({r_rem[31:0], r_base[0]} == '0) r_m <= '0;
                            else r_m <= ({1'b0, r_p} - {r_rem[31:0], r_base[0]}) >
                                    33'(SEGMENT_SIZE) ? (SEG_W+1)'(SEGMENT_SIZE)
                                    : (SEG_W+1)'({1'b0, r_p} - {r_rem[31:0], r_base[0]});
                        end else begin
                            if (w_trial[32:0] == '0) r_m <= '0;
                            else r_m <= ({1'b0, r_p} - w_trial[32:0]) > 33'(SEGMENT_SIZE)
                                    ? (SEG_W+1)'(SEGMENT_SIZE)
                                    : (SEG_W+1)'({1'b0, r_p} - w_trial[32:0]);
                        end
                    end
                end
                S_STRK: begin
                    if (w_m_in) begin
                        r_mwa <= r_m[SEG_W-1:0];
                        r_m   <= ({1'b0, r_p} > 33'(SEGMENT_SIZE) - 33'(r_m))
                                 ? (SEG_W+1)'(SEGMENT_SIZE) : r_m + (SEG_W+1)'(r_p);
                    end
                end
                S_COLW: r_mwa <= SEG_W'(1);
                S_COL: begin
                    if (w_col_end) begin
                        r_base <= r_base + 33'(SEGMENT_SIZE);
                    end else begin
                        if (r_mrd) begin
                            r_swa  <= r_cnt[IDX_W-1:0];
                            r_swd  <= w_val[31:0];
                            r_last <= w_val[31:0];
                            r_cnt  <= r_cnt + 1'b1;
                        end
                        r_i   <= r_i + 1'b1;
                        r_mwa <= SEG_W'(r_i + (SEG_W+1)'(2));
                    end
                end
                S_BSRD: begin
                    if (r_lo < r_hi) r_raddr <= w_mid[IDX_W-1:0];
                    else r_raddr <= r_q.position[IDX_W-1:0];
                end
                S_BSCM: begin
                    if ({1'b0, r_rdata} <= {1'b0, r_q.limit}) r_lo <= w_mid + 1'b1;
                    else r_hi <= w_mid;
                end
                S_ANSW: begin
                    o_found <= CNT_W'(r_q.position) < r_lo;
                    o_prime_value <= (CNT_W'(r_q.position) < r_lo) ? r_rdata : 32'd0;
                    o_prime_total <= TOT_W'(r_lo);
                    o_table_full <= (r_cnt >= CNT_W'(MAX_PRIMES)) && (r_q.limit > r_last);
                end
                default: ;
            endcase
        end
    end

    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;

`include "segmented_prime_sieve_core_macros.svh"
    `SPS_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_st))
    `SPS_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_PRIMES))
    `SPS_ASSERT_NEXT(a_out_after_ans, i_clk, i_rst_n, r_st == S_ANSW, o_valid)
    `SPS_ASSERT_IMP(a_found_total, i_clk, i_rst_n, o_valid && o_found, o_prime_total != '0)
endmodule
